### hdl/sha256mh_pkg.sv
// Shared types, constants and SHA-256 functions for the message hasher.
package sha256mh_pkg;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LENGTH_POS = 6'd56;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic       push;
		byte_sel_t  byte_sel;
		logic       count_inc;
		logic       load_len;
		logic       round_en;
		logic       first_round;
		logic [5:0] round_idx;
		logic       update;
		logic       clear;
		logic [2:0] word_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} dp_stat_t;

	function automatic logic [31:0] initial_h(input logic [2:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] r;
		case (idx)
			6'd0:  r = 32'h428a2f98;
			6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;
			6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;
			6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;
			6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;
			6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;
			6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;
			6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;
			6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;
			6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;
			6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;
			6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;
			6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;
			6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;
			6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;
			6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;
			6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;
			6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;
			6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;
			6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;
			6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;
			6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;
			6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;
			6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned s);
		return (x >> s) | (x << (32 - s));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

endpackage

### hdl/sha256mh_ctrl.sv
// Sequencer for byte intake, padding, compression rounds and digest output.
module sha256mh_ctrl
	import sha256mh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     byte_present,
	input  logic     last_byte,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     in_stall,
	output logic     out_valid,
	output logic [2:0] word_index,
	output logic     last_word
);

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	logic [5:0] round_q, round_d;
	logic [2:0] word_q, word_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			round_q <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			round_q <= round_d;
			word_q  <= word_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		round_d = round_q;
		word_d  = word_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (byte_present && stat.fill == FILL_LAST) begin
						state_d = ST_ROUND;
						ret_d   = last_byte ? ST_PAD_MARK : ST_IDLE;
					end else if (last_byte) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				state_d = ST_PAD_ZERO;
				if (stat.fill == FILL_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (stat.fill == LENGTH_POS) begin
					state_d = ST_PAD_LEN;
				end else if (stat.fill == FILL_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_PAD_ZERO;
				end
			end
			ST_PAD_LEN: begin
				if (stat.fill == FILL_LAST) begin
					state_d = ST_ROUND;
					ret_d   = ST_EMIT;
				end
			end
			ST_ROUND: begin
				round_d = round_q + 6'd1;
				if (round_q == ROUND_LAST) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ret_q;
			end
			ST_EMIT: begin
				if (!out_stall) begin
					word_d = word_q + 3'd1;
					if (word_q == WORD_LAST) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd             = '0;
		cmd.byte_sel    = SEL_DATA;
		cmd.round_idx   = round_q;
		cmd.word_idx    = word_q;
		in_stall        = 1'b1;
		out_valid       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.push      = in_valid & byte_present;
				cmd.count_inc = in_valid & byte_present;
			end
			ST_PAD_MARK: begin
				cmd.push     = 1'b1;
				cmd.byte_sel = SEL_MARK;
				cmd.load_len = 1'b1;
			end
			ST_PAD_ZERO: begin
				cmd.push     = (stat.fill != LENGTH_POS);
				cmd.byte_sel = SEL_ZERO;
			end
			ST_PAD_LEN: begin
				cmd.push     = 1'b1;
				cmd.byte_sel = SEL_LEN;
			end
			ST_ROUND: begin
				cmd.round_en    = 1'b1;
				cmd.first_round = (round_q == '0);
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.clear = !out_stall && (word_q == WORD_LAST);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign word_index = word_q;
	assign last_word  = (word_q == WORD_LAST);

endmodule

### hdl/sha256mh_dp.sv
// Datapath: byte/schedule shift line, round logic, chaining words, counters.
module sha256mh_dp
	import sha256mh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [7:0]  data_byte,
	output dp_stat_t    stat,
	output logic [31:0] digest_word
);

	// w_q holds the block as it fills, then serves as the rolling schedule
	logic [31:0] w_q [16];
	logic [31:0] var_q [8];
	logic [31:0] chain_q [8];
	logic [5:0]  fill_q;
	logic [63:0] count_q;
	logic [63:0] len_q;

	logic [7:0]  push_byte;
	logic [31:0] v [8];
	logic [31:0] t1, t2, w_new;

	always_comb begin
		case (cmd.byte_sel)
			SEL_DATA: push_byte = data_byte;
			SEL_MARK: push_byte = PAD_MARK;
			SEL_LEN:  push_byte = len_q[63:56];
			default:  push_byte = 8'h00;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			v[i] = cmd.first_round ? chain_q[i] : var_q[i];
		end
		t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
			+ round_k(cmd.round_idx) + w_q[0];
		t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
		w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	// shift line and working variables: payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], push_byte};
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (cmd.round_en) begin
			var_q[7] <= v[6];
			var_q[6] <= v[5];
			var_q[5] <= v[4];
			var_q[4] <= v[3] + t1;
			var_q[3] <= v[2];
			var_q[2] <= v[1];
			var_q[1] <= v[0];
			var_q[0] <= t1 + t2;
		end
		if (cmd.load_len) begin
			len_q <= {count_q[60:0], 3'b000};
		end else if (cmd.push && cmd.byte_sel == SEL_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= initial_h(3'(i));
			end
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + 64'd1;
			end
			if (cmd.clear) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= initial_h(3'(i));
				end
			end else if (cmd.update) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + var_q[i];
				end
			end
		end
	end

	assign stat.fill   = fill_q;
	assign digest_word = chain_q[cmd.word_idx];

endmodule

### hdl/sha256_message_hasher_core.sv
// Top level of the SHA-256 message hasher: controller plus datapath.
//
// Input channel (in_valid / in_stall): one transfer per message byte,
// data_byte qualified by byte_present; last_byte marks the final transfer,
// which may carry no byte so an empty message can be hashed.
// Output channel (out_valid / out_stall): eight transfers per message,
// digest_word with word_index 0..7, last_word set on the eighth.
// Rates: bytes are taken one per cycle while idle; each 64th byte starts a
// compression of 64 rounds (one per cycle through the single round unit,
// plus the chaining add), during which in_stall stays high.
// On a final transfer padding is pushed one byte per cycle (up to 72 bytes),
// paused by one or two compressions, before the digest is offered.
// in_stall is high whenever the block is not idle waiting for bytes.
// A stalled output word holds its value; the block waits in the output
// phase, and after the eighth word returns to the initial hash state.
// Reset (arst_n low) loads the initial hash values and clears the counters.
module sha256_message_hasher_core
	import sha256mh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha256mh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.byte_present (byte_present),
		.last_byte    (last_byte),
		.out_stall    (out_stall),
		.stat         (stat),
		.cmd          (cmd),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	sha256mh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.stat        (stat),
		.digest_word (digest_word)
	);

endmodule

### tb/tb_top.sv
// Self-checking testbench for the SHA-256 message hasher core.
module tb_top
	import sha256mh_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// One input transfer as queued for the driver. hold_off is local to the
	// bench: the driver waits for every outstanding digest word before
	// offering an item that carries it.
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
		logic       hold_off;
	} feed_t;

	// One digest word as it should leave the block
	typedef struct {
		logic [31:0] word;
		logic [2:0]  pos;
		logic        fin;
	} digest_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_message_hasher_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// SHA-256 predictor: own copy of the chaining words, block buffer,
	// fill level and message length.
	// ------------------------------------------------------------------
	logic [31:0] hash_init [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0] round_const [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic [31:0] hash_state [8];
	logic [7:0]  msg_block [64];
	logic [5:0]  block_fill;
	logic [63:0] msg_len;

	digest_out_t digest_expect [$];
	feed_t       pending [$];

	int unsigned err_count = 0;
	int unsigned items_taken = 0;
	int unsigned bytes_taken = 0;
	int unsigned msgs_hashed = 0;
	int unsigned words_checked = 0;
	int unsigned shortest_msg = 32'hffff_ffff;
	int unsigned longest_msg = 0;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Full 64-round compression of msg_block into hash_state
	function automatic void hash_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
			t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[t] + w[t];
			s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
			t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		msg_block[block_fill] = b;
		if (block_fill == FILL_LAST) begin
			hash_block();
			block_fill = '0;
		end else begin
			block_fill = block_fill + 6'd1;
		end
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_init[i];
		block_fill = '0;
		msg_len = '0;
	endfunction

	// Applies one accepted transfer; on a final transfer pads the message,
	// queues the eight digest words and starts afresh.
	function automatic void hash_transfer(input feed_t it);
		logic [63:0] bit_len;
		digest_out_t dw;
		if (it.present) begin
			msg_len = msg_len + 64'd1;
			absorb_byte(it.data);
			bytes_taken++;
		end
		if (it.last) begin
			bit_len = msg_len << 3;
			if (msg_len < shortest_msg) shortest_msg = 32'(msg_len);
			if (msg_len > longest_msg) longest_msg = 32'(msg_len);
			absorb_byte(PAD_MARK);
			while (block_fill != LENGTH_POS)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(bit_len[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				dw.word = hash_state[i];
				dw.pos = i[2:0];
				dw.fin = (i[2:0] == WORD_LAST);
				digest_expect.push_back(dw);
			end
			msgs_hashed++;
			restart_hash();
		end
	endfunction

	function automatic void add_item(input logic [7:0] d, input logic p, input logic l,
		input logic h);
		feed_t it;
		it.data = d;
		it.present = p;
		it.last = l;
		it.hold_off = h;
		pending.push_back(it);
	endfunction

	initial restart_hash();

	// ------------------------------------------------------------------
	// Driver: both channels change on the falling edge. in_took carries
	// the outcome of the last rising edge, so a stalled transfer is held
	// unchanged and a completed one is replaced or withdrawn.
	// Idling comes in bursts, enabled in windows of random length so that
	// there are also long stretches at full rate; none in the tail.
	// ------------------------------------------------------------------
	logic        in_took = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned mode_left = 0;
	bit          idle_mode = 1'b0;
	bit          calm;
	feed_t       next_item;

	always @(negedge clk) begin
		calm = (pending.size() < 30);
		if (mode_left == 0) begin
			idle_mode = 1'($urandom_range(0, 1));
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end

		if (arst_n) begin
			// sender side
			if (in_valid && !in_took) begin
				// stalled: hold the transfer as it is
			end else if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending[0].hold_off && digest_expect.size() != 0) begin
				// let the previous digest drain completely first
				in_valid <= 1'b0;
			end else if (idle_mode && !calm && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(1, 19) - 1;
				in_valid <= 1'b0;
			end else begin
				next_item = pending.pop_front();
				data_byte <= next_item.data;
				byte_present <= next_item.present;
				last_byte <= next_item.last;
				in_valid <= 1'b1;
			end

			// receiver side
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_mode && !calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: on the rising edge, checks each digest word transfer against
	// the oldest prediction and feeds each accepted input transfer to the
	// predictor.
	// ------------------------------------------------------------------
	digest_out_t want;

	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (digest_expect.size() == 0) begin
					$error("digest word %h (index %0d) with none outstanding",
						digest_word, word_index);
					err_count++;
				end else begin
					want = digest_expect.pop_front();
					words_checked++;
					if (digest_word !== want.word) begin
						$error("digest_word: expected %h, got %h", want.word, digest_word);
						err_count++;
					end
					if (word_index !== want.pos) begin
						$error("word_index: expected %0d, got %0d", want.pos, word_index);
						err_count++;
					end
					if (last_word !== want.fin) begin
						$error("last_word: expected %b, got %b", want.fin, last_word);
						err_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				hash_transfer('{data_byte, byte_present, last_byte, 1'b0});
				items_taken++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin : stimulus
		int  len;
		int  queued;
		int  body;
		bit  ride;
		bit  hold;
		bit  first;

		// empty message, also with a no-op transfer ahead of the final one
		add_item(8'h00, 1'b0, 1'b1, 1'b0);
		add_item(8'ha5, 1'b0, 1'b0, 1'b0);
		add_item(8'h5a, 1'b0, 1'b1, 1'b0);
		// one-byte messages with the byte riding on the final transfer
		add_item(8'h00, 1'b1, 1'b1, 1'b0);
		add_item(8'hff, 1'b1, 1'b1, 1'b0);
		// "abc", after the previous digests have fully drained
		add_item(8'h61, 1'b1, 1'b0, 1'b1);
		add_item(8'h62, 1'b1, 1'b0, 1'b0);
		add_item(8'h63, 1'b1, 1'b1, 1'b0);
		// bytes, a no-op in between, then a final transfer with no byte
		add_item(8'h80, 1'b1, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0, 1'b0);
		add_item(8'h7f, 1'b1, 1'b0, 1'b0);
		add_item(8'hff, 1'b0, 1'b1, 1'b0);
		// no-op with all data bits set, then a short message
		add_item(8'hff, 1'b0, 1'b0, 1'b0);
		add_item(8'h01, 1'b1, 1'b0, 1'b0);
		add_item(8'hfe, 1'b1, 1'b1, 1'b0);

		// Random messages: mostly short, a third around the padding and
		// block boundaries (one or two padding blocks, multi-block bodies).
		// The last message is trimmed so the run stays near 170 transfers.
		queued = 0;
		first = 1'b1;
		while (queued < 150) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 5))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					default: len = 119 + $urandom_range(0, 1);
				endcase
			end else begin
				len = $urandom_range(0, 15);
			end
			if (queued + len > 155)
				len = 155 - queued;
			ride = (len != 0) && ($urandom_range(0, 1) == 1);
			hold = first || ($urandom_range(0, 3) == 0);
			body = len - ride;
			for (int i = 0; i < body; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
					queued++;
				end
				add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, hold && (i == 0));
			end
			add_item(8'($urandom_range(0, 255)), ride, 1'b1, hold && (body == 0));
			queued += body + 1;
			first = 1'b0;
		end

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (digest_expect.size() != 0)
			@(posedge clk);
		// room for any stray words after the last digest
		repeat (200) @(posedge clk);

		$display("Covered %0d input transfers (%0d message bytes),",
			items_taken, bytes_taken);
		$display("%0d messages of %0d to %0d bytes, %0d digest words compared, %0d mismatches.",
			msgs_hashed, shortest_msg, longest_msg, words_checked, err_count);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
hdl/sha256mh_pkg.sv
hdl/sha256mh_ctrl.sv
hdl/sha256mh_dp.sv
hdl/sha256_message_hasher_core.sv
tb/tb_top.sv
